### hdl/ohds_pkg.sv
// ----------------------------------------------------------------------------
// ohds_pkg: shared types and constants of the one-wire serial engine
// Holds the command codes, the lead character of a frame, the decoded item
// that travels from the front end to the engine, and the frame byte selector.
// ----------------------------------------------------------------------------
package ohds_pkg;

  // Command codes of the opcode field; the engine mode uses the same codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;
  localparam logic [1:0] OP_FRAME = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_TX    = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;
  localparam logic [1:0] MODE_FRAME = 2'd3;

  // Every frame opens with an ASCII 'a'.
  localparam logic [7:0] LEAD_CHAR = 8'h61;

  // Configuration register indexes.
  localparam logic REG_HALF_BIT = 1'b0;
  localparam logic REG_FULL_BIT = 1'b1;

  // Timing registers as seen by the engine.
  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [15:0] full_bit_ticks;
  } cfg_t;

  // One tick after decoding by the front end.
  typedef struct packed {
    logic        is_cmd;      // a command is carried by this tick
    logic [1:0]  mode;        // mode that the command would start
    logic [7:0]  first_byte;  // first byte loaded into the shifter
    logic [31:0] words;       // frame words, word_b in the upper half
    logic        line_level;
  } item_t;

  // One result as produced by the engine.
  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       pullup_enable;
    logic [7:0] received_byte;
    logic       received_valid;
    logic       byte_sent;
    logic       frame_sent;
    logic       busy_res;
    logic       command_rejected;
  } res_t;

  // Byte of a frame at a given position: lead, A low, B low, A high, B high.
  function automatic logic [7:0] frame_byte(input logic [31:0] words,
                                            input logic [2:0]  pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = LEAD_CHAR;
      3'd1:    b = words[7:0];
      3'd2:    b = words[23:16];
      3'd3:    b = words[15:8];
      default: b = words[31:24];
    endcase
    return b;
  endfunction

endpackage

### hdl/one_wire_half_duplex_serial.sv
// ----------------------------------------------------------------------------
// one_wire_half_duplex_serial: half-duplex single-wire serial engine
// Each transfer on the input channel is one fine tick of the wire, with the
// sampled line level and an optional command (send byte, receive byte, send
// a five-byte frame). Each tick yields one result transfer with the line
// controls, the receive data and the status flags after that tick.
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------
//   in_       | in_valid / in_ready    | opcode, send_byte, word_a, word_b,
//             |                        | line_level
//   out_      | out_valid / out_ready  | drive/pull-up controls, received
//             |                        | byte and flags, busy, rejected
//   config    | psel/penable/pwrite    | half_bit_ticks at 0x0,
//             | pready (always high)   | full_bit_ticks at 0x4
//
// One tick is taken every clock cycle while in_ready is high. An accepted tick
// is written into the queue and then stepped by the engine into its output
// register once that register is free, so a stalled result holds it back.
// The engine's state update sets the rate.
// Reset is synchronous and active low; it returns the engine to idle, empties
// the queue and loads the timing registers with 52 and 104. No clearing pass
// is needed. A stalled result channel fills the queue, after which in_ready
// drops; the input side never stalls the engine otherwise.
// ----------------------------------------------------------------------------
module one_wire_half_duplex_serial #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Tick input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_send_byte,
  input  logic [15:0] in_word_a,
  input  logic [15:0] in_word_b,
  input  logic        in_line_level,
  // Result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_enable,
  output logic        out_drive_level,
  output logic        out_pullup_enable,
  output logic [7:0]  out_received_byte,
  output logic        out_received_valid,
  output logic        out_byte_sent,
  output logic        out_frame_sent,
  output logic        out_busy_res,
  output logic        out_command_rejected,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] half_bit_ticks_r;
  logic [15:0] full_bit_ticks_r;
  logic        cfg_write;
  logic        reg_sel;

  ohds_pkg::cfg_t  cfg;
  ohds_pkg::item_t front_item;
  ohds_pkg::item_t head_item;
  ohds_pkg::res_t  res;

  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic in_xfer;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only the word index bit of the address is
  // decoded, so each register also answers at the unaligned byte addresses
  // of its word. Writes are expected only while the engine is idle.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_ticks_r <= 16'd52;
      full_bit_ticks_r <= 16'd104;
    end else if (cfg_write) begin
      if (reg_sel == ohds_pkg::REG_HALF_BIT) begin
        half_bit_ticks_r <= pwdata[15:0];
      end else begin
        full_bit_ticks_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (reg_sel == ohds_pkg::REG_HALF_BIT) ? {16'h0000, half_bit_ticks_r}
                                                      : {16'h0000, full_bit_ticks_r};

  assign cfg.half_bit_ticks = half_bit_ticks_r;
  assign cfg.full_bit_ticks = full_bit_ticks_r;

  // ---------------------------------------------------------------------------
  // Front end: decode the tick and push it into the queue.
  // ---------------------------------------------------------------------------
  assign in_ready = !q_full;
  assign in_xfer  = in_valid && in_ready;

  ohds_front u_front (
    .opcode     (in_opcode),
    .send_byte  (in_send_byte),
    .word_a     (in_word_a),
    .word_b     (in_word_b),
    .line_level (in_line_level),
    .item       (front_item)
  );

  ohds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head_item (head_item)
  );

  // ---------------------------------------------------------------------------
  // Back end: the line engine steps once for every queued tick whose result
  // can be placed in the output register.
  // ---------------------------------------------------------------------------
  ohds_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign out_drive_enable     = res.drive_enable;
  assign out_drive_level      = res.drive_level;
  assign out_pullup_enable    = res.pullup_enable;
  assign out_received_byte    = res.received_byte;
  assign out_received_valid   = res.received_valid;
  assign out_byte_sent        = res.byte_sent;
  assign out_frame_sent       = res.frame_sent;
  assign out_busy_res         = res.busy_res;
  assign out_command_rejected = res.command_rejected;

endmodule

### hdl/ohds_front.sv
// ----------------------------------------------------------------------------
// ohds_front: input decoder of the one-wire serial engine
// Classifies each tick into an idle tick or a command and prepares the
// preload values of the engine, so that the engine only selects them.
// ----------------------------------------------------------------------------
module ohds_front (
  input  logic [1:0]     opcode,
  input  logic [7:0]     send_byte,
  input  logic [15:0]    word_a,
  input  logic [15:0]    word_b,
  input  logic           line_level,
  output ohds_pkg::item_t item
);

  logic [31:0] words;

  assign words = {word_b, word_a};

  always_comb begin
    item.is_cmd     = (opcode != ohds_pkg::OP_TICK);
    item.mode       = opcode;
    item.words      = words;
    item.line_level = line_level;
    unique case (opcode)
      ohds_pkg::OP_SEND:  item.first_byte = send_byte;
      ohds_pkg::OP_FRAME: item.first_byte = ohds_pkg::frame_byte(words, 3'd0);
      default:            item.first_byte = 8'h00;
    endcase
  end

endmodule

### hdl/ohds_queue.sv
// ----------------------------------------------------------------------------
// ohds_queue: short queue between the front end and the engine
// A small circular buffer of decoded ticks with a fill count.
// ----------------------------------------------------------------------------
module ohds_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ohds_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output ohds_pkg::item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ohds_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign nonempty  = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/ohds_engine.sv
// ----------------------------------------------------------------------------
// ohds_engine: line engine of the one-wire serial block
// Advances the send/receive state machine by one tick per queued item and
// holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ohds_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  ohds_pkg::cfg_t  cfg,
  input  logic            q_nonempty,
  input  ohds_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output ohds_pkg::res_t  res
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_HALF = 3'd1;
  localparam logic [2:0] PH_PULL = 3'd2;
  localparam logic [2:0] PH_LEAD = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [1:0]  mode_r,  mode_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] tick_r,  tick_nxt;
  logic [2:0]  bit_r,   bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [31:0] words_r, words_nxt;
  logic [2:0]  pos_r,   pos_nxt;
  logic [7:0]  last_r,  last_nxt;
  logic        out_valid_r, out_valid_nxt;
  ohds_pkg::res_t res_r, res_nxt;

  logic        step;
  logic        taken;
  logic        sending;
  logic [16:0] tick_inc;
  logic [16:0] half_eff;
  logic [16:0] full_eff;
  logic [7:0]  shift_rx;

  assign step      = q_nonempty && (!out_valid_r || out_ready);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign half_eff = (cfg.half_bit_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.half_bit_ticks};
  assign full_eff = (cfg.full_bit_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.full_bit_ticks};
  assign shift_rx = {shift_r[6:0], q_item.line_level};

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    words_nxt = words_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    taken     = 1'b0;
    res_nxt   = '0;

    if (q_item.is_cmd) begin
      if (mode_r != ohds_pkg::MODE_IDLE) begin
        res_nxt.command_rejected = 1'b1;
      end else begin
        taken     = 1'b1;
        phase_nxt = PH_WAIT;
        tick_nxt  = '0;
        bit_nxt   = '0;
        pos_nxt   = '0;
        mode_nxt  = q_item.mode;
        shift_nxt = q_item.first_byte;
        if (q_item.mode == ohds_pkg::MODE_FRAME) begin
          words_nxt = q_item.words;
        end
      end
    end

    if (!taken && mode_r != ohds_pkg::MODE_IDLE) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (!q_item.line_level) begin
            phase_nxt = PH_HALF;
            tick_nxt  = '0;
          end
        end
        PH_HALF: begin
          tick_nxt = tick_inc[15:0];
          if (tick_inc >= half_eff) begin
            tick_nxt  = '0;
            bit_nxt   = '0;
            phase_nxt = (mode_r == ohds_pkg::MODE_RX) ? PH_DATA : PH_PULL;
          end
        end
        PH_PULL: begin
          tick_nxt = tick_inc[15:0];
          if (tick_inc >= full_eff) begin
            tick_nxt  = '0;
            phase_nxt = PH_LEAD;
          end
        end
        PH_LEAD: begin
          tick_nxt = tick_inc[15:0];
          if (tick_inc >= full_eff) begin
            tick_nxt  = '0;
            bit_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        default: begin
          tick_nxt = tick_inc[15:0];
          if (tick_inc >= full_eff) begin
            tick_nxt = '0;
            if (mode_r == ohds_pkg::MODE_RX) begin
              shift_nxt = shift_rx;
            end
            if (bit_r == 3'd7) begin
              bit_nxt   = '0;
              phase_nxt = PH_WAIT;
              if (mode_r == ohds_pkg::MODE_RX) begin
                last_nxt               = shift_rx;
                res_nxt.received_valid = 1'b1;
                mode_nxt               = ohds_pkg::MODE_IDLE;
              end else begin
                res_nxt.byte_sent = 1'b1;
                if (mode_r == ohds_pkg::MODE_FRAME && pos_r < 3'd4) begin
                  pos_nxt   = pos_r + 3'd1;
                  shift_nxt = ohds_pkg::frame_byte(words_r, pos_r + 3'd1);
                end else begin
                  res_nxt.frame_sent = (mode_r == ohds_pkg::MODE_FRAME);
                  pos_nxt            = '0;
                  mode_nxt           = ohds_pkg::MODE_IDLE;
                end
              end
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
      endcase
    end

    // Line controls follow the state after this tick.
    sending = (mode_nxt == ohds_pkg::MODE_TX) || (mode_nxt == ohds_pkg::MODE_FRAME);
    if (sending) begin
      if (phase_nxt == PH_PULL) begin
        res_nxt.pullup_enable = 1'b1;
      end else if (phase_nxt == PH_LEAD) begin
        res_nxt.drive_enable = 1'b1;
        res_nxt.drive_level  = 1'b1;
      end else if (phase_nxt == PH_DATA) begin
        res_nxt.drive_enable = 1'b1;
        res_nxt.drive_level  = shift_nxt[3'd7 - bit_nxt];
      end
    end
    res_nxt.received_byte = last_nxt;
    res_nxt.busy_res      = (mode_nxt != ohds_pkg::MODE_IDLE);
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ohds_pkg::MODE_IDLE;
      phase_r     <= PH_WAIT;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      words_r     <= '0;
      pos_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        mode_r  <= mode_nxt;
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        words_r <= words_nxt;
        pos_r   <= pos_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule

### hdl/ohds_checker.sv
// ----------------------------------------------------------------------------
// ohds_checker: port-level checks of the one-wire serial engine
// Watches the result channel for consistency between line controls and
// status flags, and for a held result while it is stalled.
// ----------------------------------------------------------------------------
module ohds_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_drive_enable,
  input logic out_drive_level,
  input logic out_pullup_enable,
  input logic out_received_valid,
  input logic out_byte_sent,
  input logic out_frame_sent,
  input logic out_busy_res
);

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_level)
      && $stable(out_busy_res) && $stable(out_byte_sent))
    else $error("result changed while stalled");

  // The last frame byte is also a sent byte, and never coincides with a receive.
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_sent |-> out_byte_sent && !out_received_valid
      && !out_busy_res)
    else $error("frame completion flags inconsistent");

  // The pull-up is only on during a send, and never while driving.
  a_pullup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pullup_enable |-> out_busy_res && !out_drive_enable)
    else $error("pull-up on outside a send bit time");

  // A high level is only shown while driving during a command.
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_level |-> out_drive_enable && out_busy_res)
    else $error("drive level without drive");

endmodule

bind one_wire_half_duplex_serial ohds_checker u_ohds_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_drive_enable   (out_drive_enable),
  .out_drive_level    (out_drive_level),
  .out_pullup_enable  (out_pullup_enable),
  .out_received_valid (out_received_valid),
  .out_byte_sent      (out_byte_sent),
  .out_frame_sent     (out_frame_sent),
  .out_busy_res       (out_busy_res)
);

### tb/one_wire_half_duplex_serial_test.sv
// ----------------------------------------------------------------------------
// one_wire_half_duplex_serial_test: self-checking bench for the one-wire engine
// Every tick transfer is mirrored by a tick-true model of the engine that
// lives in a small tracker class. The tracker queues the result it expects
// for each accepted tick and checks every result transfer against it, field
// by field. The run opens at the reset timing, walks through directed sends,
// receives, frames and refused commands at the shortest bit times, then
// several random phases with different timing and idling, and closes with
// the longest bit time.
// ----------------------------------------------------------------------------
module one_wire_half_duplex_serial_test;

  // Generous cycle limit.
  localparam int unsigned RUN_LIMIT = 1_000_000;
  // Receiver hold-off used to back the engine up into its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // Cycles allowed for the last result to leave the block.
  localparam int unsigned SETTLE_CYCLES = 10;

  // How the line behaves once a byte has started.
  localparam int LINE_LOW    = 0;
  localparam int LINE_HIGH   = 1;
  localparam int LINE_RANDOM = 2;

  // Progress of one byte on the wire, as the engine sees it.
  typedef enum logic [2:0] {
    WAIT_START,
    HALF_BIT,
    PULL_UP,
    LEAD_BIT,
    DATA_BITS
  } wire_phase_e;

  // One tick as offered on the input channel.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  send_byte;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        line;
  } tick_t;

  // Tracks the engine state, predicts the result of every accepted tick and
  // checks result transfers in order against those predictions.
  class wire_engine_tracker;
    logic [15:0]    half_ticks;
    logic [15:0]    full_ticks;
    logic [1:0]     mode;
    wire_phase_e    phase;
    int unsigned    count;
    int unsigned    bit_pos;
    int unsigned    frame_pos;
    logic [7:0]     shifter;
    logic [31:0]    words;
    logic [7:0]     last_rx;
    ohds_pkg::res_t predicted_results[$];
    int unsigned    results_seen;
    int unsigned    errors;

    function new();
      half_ticks   = 16'd52;
      full_ticks   = 16'd104;
      mode         = ohds_pkg::MODE_IDLE;
      phase        = WAIT_START;
      count        = 0;
      bit_pos      = 0;
      frame_pos    = 0;
      shifter      = '0;
      words        = '0;
      last_rx      = '0;
      results_seen = 0;
      errors       = 0;
    endfunction

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void set_timing(input logic idx, input logic [15:0] value);
      if (idx == ohds_pkg::REG_HALF_BIT) half_ticks = value;
      else full_ticks = value;
    endfunction

    // A timing register of zero behaves as one tick.
    function int unsigned ticks_or_one(input logic [15:0] value);
      return (value == 16'd0) ? 1 : int'(value);
    endfunction

    function logic [7:0] frame_octet(input int unsigned pos);
      case (pos)
        0:       return ohds_pkg::LEAD_CHAR;
        1:       return words[7:0];
        2:       return words[23:16];
        3:       return words[15:8];
        default: return words[31:24];
      endcase
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction

    function void note_tick(input tick_t t);
      ohds_pkg::res_t r;
      logic           loaded;
      int unsigned    full_n;
      r      = '0;
      loaded = 1'b0;
      full_n = ticks_or_one(full_ticks);

      if (t.opcode != ohds_pkg::OP_TICK) begin
        if (mode != ohds_pkg::MODE_IDLE) begin
          r.command_rejected = 1'b1;
        end else begin
          loaded    = 1'b1;
          phase     = WAIT_START;
          count     = 0;
          bit_pos   = 0;
          frame_pos = 0;
          case (t.opcode)
            ohds_pkg::OP_SEND: begin
              mode    = ohds_pkg::MODE_TX;
              shifter = t.send_byte;
            end
            ohds_pkg::OP_RECV: begin
              mode    = ohds_pkg::MODE_RX;
              shifter = '0;
            end
            default: begin
              mode    = ohds_pkg::MODE_FRAME;
              words   = {t.word_b, t.word_a};
              shifter = ohds_pkg::LEAD_CHAR;
            end
          endcase
        end
      end

      // The tick that loads a command does nothing else.
      if (!loaded && mode != ohds_pkg::MODE_IDLE) begin
        case (phase)
          WAIT_START: begin
            if (!t.line) begin
              phase = HALF_BIT;
              count = 0;
            end
          end
          HALF_BIT: begin
            count++;
            if (count >= ticks_or_one(half_ticks)) begin
              count   = 0;
              bit_pos = 0;
              phase   = (mode == ohds_pkg::MODE_RX) ? DATA_BITS : PULL_UP;
            end
          end
          PULL_UP: begin
            count++;
            if (count >= full_n) begin
              count = 0;
              phase = LEAD_BIT;
            end
          end
          LEAD_BIT: begin
            count++;
            if (count >= full_n) begin
              count   = 0;
              bit_pos = 0;
              phase   = DATA_BITS;
            end
          end
          default: begin
            count++;
            if (count >= full_n) begin
              count = 0;
              if (mode == ohds_pkg::MODE_RX) shifter = {shifter[6:0], t.line};
              bit_pos++;
              if (bit_pos >= 8) begin
                bit_pos = 0;
                phase   = WAIT_START;
                if (mode == ohds_pkg::MODE_RX) begin
                  last_rx          = shifter;
                  r.received_valid = 1'b1;
                  mode             = ohds_pkg::MODE_IDLE;
                end else begin
                  r.byte_sent = 1'b1;
                  if (mode == ohds_pkg::MODE_FRAME && frame_pos < 4) begin
                    frame_pos++;
                    shifter = frame_octet(frame_pos);
                  end else begin
                    r.frame_sent = (mode == ohds_pkg::MODE_FRAME);
                    frame_pos    = 0;
                    mode         = ohds_pkg::MODE_IDLE;
                  end
                end
              end
            end
          end
        endcase
      end

      if (mode == ohds_pkg::MODE_TX || mode == ohds_pkg::MODE_FRAME) begin
        case (phase)
          PULL_UP:  r.pullup_enable = 1'b1;
          LEAD_BIT: begin
            r.drive_enable = 1'b1;
            r.drive_level  = 1'b1;
          end
          DATA_BITS: begin
            if (bit_pos < 8) begin
              r.drive_enable = 1'b1;
              r.drive_level  = shifter[7 - bit_pos];
            end
          end
          default: ;
        endcase
      end
      r.received_byte = last_rx;
      r.busy_res      = (mode != ohds_pkg::MODE_IDLE);
      predicted_results.push_back(r);
    endfunction

    task compare(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_seen, name, got, want));
    endtask

    task check_result(input ohds_pkg::res_t got);
      ohds_pkg::res_t want;
      if (predicted_results.size() == 0) begin
        report($sformatf("result %0d arrived with no tick waiting", results_seen));
        results_seen++;
        return;
      end
      want = predicted_results.pop_front();
      compare("drive_enable", got.drive_enable, want.drive_enable);
      compare("drive_level", got.drive_level, want.drive_level);
      compare("pullup_enable", got.pullup_enable, want.pullup_enable);
      compare("received_byte", got.received_byte, want.received_byte);
      compare("received_valid", got.received_valid, want.received_valid);
      compare("byte_sent", got.byte_sent, want.byte_sent);
      compare("frame_sent", got.frame_sent, want.frame_sent);
      compare("busy_res", got.busy_res, want.busy_res);
      compare("command_rejected", got.command_rejected, want.command_rejected);
      results_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_send_byte;
  logic [15:0] in_word_a;
  logic [15:0] in_word_b;
  logic        in_line_level;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_drive_enable;
  logic        out_drive_level;
  logic        out_pullup_enable;
  logic [7:0]  out_received_byte;
  logic        out_received_valid;
  logic        out_byte_sent;
  logic        out_frame_sent;
  logic        out_busy_res;
  logic        out_command_rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wire_engine_tracker sb = new();

  // Idling percentages of the two sides, changed phase by phase.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  // The main sequence asks for a receiver hold-off by bumping hold_orders.
  int unsigned hold_orders  = 0;
  int unsigned hold_taken   = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  one_wire_half_duplex_serial DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_send_byte         (in_send_byte),
    .in_word_a            (in_word_a),
    .in_word_b            (in_word_b),
    .in_line_level        (in_line_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive_enable     (out_drive_enable),
    .out_drive_level      (out_drive_level),
    .out_pullup_enable    (out_pullup_enable),
    .out_received_byte    (out_received_byte),
    .out_received_valid   (out_received_valid),
    .out_byte_sent        (out_byte_sent),
    .out_frame_sent       (out_frame_sent),
    .out_busy_res         (out_busy_res),
    .out_command_rejected (out_command_rejected),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver side. A requested hold-off is counted out here, in its own
  // process, while the sender carries on; otherwise ready is random.
  always @(posedge clk) begin
    if (hold_orders != hold_taken) begin
      hold_taken = hold_orders;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Every result transfer is checked against the oldest prediction. Outputs
  // are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin : watch_results
    ohds_pkg::res_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{drive_enable:     out_drive_enable,
               drive_level:      out_drive_level,
               pullup_enable:    out_pullup_enable,
               received_byte:    out_received_byte,
               received_valid:   out_received_valid,
               byte_sent:        out_byte_sent,
               frame_sent:       out_frame_sent,
               busy_res:         out_busy_res,
               command_rejected: out_command_rejected};
      sb.check_result(seen);
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tick_t make_tick(input logic [1:0] op, input logic [7:0] b,
                                      input logic [15:0] a, input logic [15:0] w,
                                      input logic line);
    tick_t t;
    t.opcode    = op;
    t.send_byte = b;
    t.word_a    = a;
    t.word_b    = w;
    t.line      = line;
    return t;
  endfunction

  // Mostly well-formed traffic: when the engine is free a command follows half
  // the time, when busy an occasional stray command tests the refusal, and
  // the partner pulls the line low fairly soon while a byte waits to start.
  function automatic tick_t random_tick();
    logic [1:0] op;
    logic       line;
    if (sb.mode == ohds_pkg::MODE_IDLE)
      op = ($urandom_range(99) < 50)
           ? 2'($urandom_range(ohds_pkg::OP_FRAME, ohds_pkg::OP_SEND))
           : ohds_pkg::OP_TICK;
    else
      op = ($urandom_range(99) < 5)
           ? 2'($urandom_range(ohds_pkg::OP_FRAME, ohds_pkg::OP_SEND))
           : ohds_pkg::OP_TICK;
    if (sb.mode != ohds_pkg::MODE_IDLE && sb.phase == WAIT_START)
      line = ($urandom_range(99) < 30);
    else
      line = 1'($urandom_range(1));
    return make_tick(op, 8'($urandom), 16'($urandom), 16'($urandom), line);
  endfunction

  // Offers one tick, with random idle cycles first, and holds it until the
  // block takes the transfer. Called and returning at a rising edge.
  task automatic drive_tick(input tick_t t);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= t.opcode;
    in_send_byte  <= t.send_byte;
    in_word_a     <= t.word_a;
    in_word_b     <= t.word_b;
    in_line_level <= t.line;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  // Plain ticks until the engine has finished its command. While a byte
  // waits for its start the line is mostly low; once it runs the line
  // follows the requested pattern.
  task automatic run_to_idle(input int data_line);
    logic line;
    while (sb.mode != ohds_pkg::MODE_IDLE) begin
      if (sb.phase == WAIT_START)
        line = ($urandom_range(3) == 0);
      else if (data_line == LINE_RANDOM)
        line = 1'($urandom_range(1));
      else
        line = (data_line == LINE_HIGH);
      drive_tick(make_tick(ohds_pkg::OP_TICK, 8'($urandom), 16'($urandom),
                           16'($urandom), line));
    end
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) drive_tick(random_tick());
  endtask

  // Stops offering ticks until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Reads a register back; the data is taken in the completing access cycle.
  task automatic check_reg(input logic idx, input logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, want})
      sb.report($sformatf("register at %0h reads %0h, expected %0h",
                          {idx, 2'b00}, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a timing register with junk in the unused upper half, then reads
  // it back. The register takes the value at the completing access edge.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_timing(idx, value);
    check_reg(idx, value);
  endtask

  // New timing only once the engine is free and nothing is in flight.
  task automatic retime(input logic [15:0] half, input logic [15:0] full);
    run_to_idle(LINE_RANDOM);
    drain_results();
    repeat (4) @(posedge clk);
    write_reg(ohds_pkg::REG_HALF_BIT, half);
    write_reg(ohds_pkg::REG_FULL_BIT, full);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = ohds_pkg::OP_TICK;
    in_send_byte  = '0;
    in_word_a     = '0;
    in_word_b     = '0;
    in_line_level = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: both registers read back their reset values, and one
    // full receive runs at the slow default bit time.
    check_reg(ohds_pkg::REG_HALF_BIT, 16'd52);
    check_reg(ohds_pkg::REG_FULL_BIT, 16'd104);
    drive_tick(make_tick(ohds_pkg::OP_RECV, 8'h00, 16'h0000, 16'h0000, 1'b1));
    run_to_idle(LINE_RANDOM);

    // Directed part at the shortest bit times.
    retime(16'd1, 16'd1);
    drive_tick(make_tick(ohds_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0));
    drive_tick(make_tick(ohds_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1));
    // A command whose own tick has the line low must still wait a tick
    // before it can see its start.
    drive_tick(make_tick(ohds_pkg::OP_SEND, 8'h00, 16'h0000, 16'h0000, 1'b0));
    run_to_idle(LINE_RANDOM);
    drive_tick(make_tick(ohds_pkg::OP_SEND, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
    run_to_idle(LINE_RANDOM);
    drive_tick(make_tick(ohds_pkg::OP_RECV, 8'h00, 16'h0000, 16'h0000, 1'b0));
    run_to_idle(LINE_HIGH);
    drive_tick(make_tick(ohds_pkg::OP_RECV, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
    run_to_idle(LINE_LOW);
    drive_tick(make_tick(ohds_pkg::OP_RECV, 8'h00, 16'h0000, 16'h0000, 1'b0));
    run_to_idle(LINE_RANDOM);
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'h00, 16'hFFFF, 16'h0000, 1'b0));
    run_to_idle(LINE_RANDOM);
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'hFF, 16'h0000, 16'hFFFF, 1'b1));
    run_to_idle(LINE_RANDOM);
    // Commands arriving while busy are refused and the send runs on.
    drive_tick(make_tick(ohds_pkg::OP_SEND, 8'h3C, 16'h1234, 16'hABCD, 1'b1));
    drive_tick(make_tick(ohds_pkg::OP_RECV, 8'h00, 16'h0000, 16'h0000, 1'b1));
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'h00, 16'h1234, 16'hABCD, 1'b0));
    drive_tick(make_tick(ohds_pkg::OP_SEND, 8'hC3, 16'h0000, 16'h0000, 1'b0));
    run_to_idle(LINE_RANDOM);
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'h00, 16'h1234, 16'hABCD, 1'b0));
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'h00, 16'h5678, 16'h9ABC, 1'b0));
    run_to_idle(LINE_RANDOM);

    // Random phase with a slow sender.
    tx_idle_pct  = 56;
    rx_stall_pct = 0;
    retime(16'd2, 16'd3);
    run_random(80);

    // Zero timing acts as one tick. The receiver stalls, and part way through
    // it holds off entirely so the block backs up into its input.
    tx_idle_pct  = 0;
    rx_stall_pct = 56;
    retime(16'd0, 16'd0);
    run_random(40);
    hold_orders <= hold_orders + 1;
    run_random(100);

    // Light idling on both sides, with a pause until every result is home.
    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    retime(16'd5, 16'd2);
    run_random(40);
    drain_results();
    run_random(40);

    // No idling at all.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    retime(16'd1, 16'd4);
    run_random(100);

    // Longest bit time: the send sits in its pull-up bit for the rest of
    // the run, refusing a frame on the way.
    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    retime(16'd1, 16'hFFFF);
    drive_tick(make_tick(ohds_pkg::OP_SEND, 8'hA5, 16'h0000, 16'h0000, 1'b0));
    drive_tick(make_tick(ohds_pkg::OP_FRAME, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0));
    repeat (40) drive_tick(make_tick(ohds_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0));

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
